/* hw/rtl/vvfm_pkg.sv */
// ----------------------------------------------------------------------------
// vvfm_pkg
// Shared types, codes and helpers of the voxel visible face mesher.
// ----------------------------------------------------------------------------
package vvfm_pkg;

  localparam logic [1:0] MODE_WRITE   = 2'd0;
  localparam logic [1:0] MODE_EMIT    = 2'd1;
  localparam logic [1:0] MODE_RESTART = 2'd2;

  localparam logic [2:0] FACE_TOP    = 3'd0;
  localparam logic [2:0] FACE_BOTTOM = 3'd1;
  localparam logic [2:0] FACE_FRONT  = 3'd2;
  localparam logic [2:0] FACE_BACK   = 3'd3;
  localparam logic [2:0] FACE_RIGHT  = 3'd4;
  localparam logic [2:0] FACE_LEFT   = 3'd5;

  localparam int         NUM_FACES        = 6;
  localparam logic [2:0] SCAN_LAST        = 3'd6;
  localparam logic [9:0] BLOCK_SIZE_RESET = 10'd50;
  localparam logic [19:0] VERTEX_STEP     = 20'd4;

  localparam int CMD_DEPTH = 2;
  localparam int OUT_DEPTH = 4;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_EMIT    = 2'd1,
    OP_RESTART = 2'd2
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t                  op;
    logic [3:0]               pos_x;
    logic [3:0]               pos_y;
    logic [6:0]               pos_z;
    logic                     solid;
    logic [NUM_FACES-1:0]     at_edge;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  face;
    logic [19:0] base_vertex;
    logic [13:0] world_x;
    logic [13:0] world_y;
    logic [16:0] world_z;
    logic        last;
  } result_t;

  function automatic logic [2:0] lowest_face(input logic [NUM_FACES-1:0] m);
    logic [2:0] r;
    r = FACE_TOP;
    for (int i = NUM_FACES - 1; i >= 0; i--) begin
      if (m[i]) r = 3'(i);
    end
    return r;
  endfunction

endpackage

/* hw/rtl/voxel_visible_face_mesher_top.sv */
// ----------------------------------------------------------------------------
// voxel_visible_face_mesher_top
// Culled voxel face mesher: occupancy grid plus visible face generator.
// ----------------------------------------------------------------------------
// Words are pushed into a two-entry command queue and run one at a time by
// the execution side. For an emit word the occupancy memory is read once per
// cycle for the voxel and its six neighbors; for a solid voxel one face word
// per cycle then goes into a four-entry result queue while that queue is not
// full. The occupancy memory has no clear; every voxel that an emit touches
// must have been written first.
// block_size is written through cfg_valid/cfg_data; the user must write it
// only while the block is idle, as the block itself does not enforce this.
module voxel_visible_face_mesher_top
  import vvfm_pkg::*;
#(
  parameter int GRID_X = 16,
  parameter int GRID_Y = 16,
  parameter int GRID_Z = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [9:0]  cfg_data,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  mode,
  input  logic [3:0]  pos_x,
  input  logic [3:0]  pos_y,
  input  logic [6:0]  pos_z,
  input  logic [7:0]  block_id,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  face,
  output logic [19:0] base_vertex,
  output logic [13:0] world_x,
  output logic [13:0] world_y,
  output logic [16:0] world_z,
  output logic        last
);

  cmd_t    cmd_in;
  cmd_t    cmd_head;
  logic    cmd_push;
  logic    cmd_full;
  logic    cmd_empty;
  logic    cmd_pop;
  result_t res;
  result_t res_out;
  logic    out_push;
  logic    out_full;

  assign cfg_ready = 1'b1;
  assign full      = cmd_full;

  vvfm_front #(
    .GRID_X(GRID_X),
    .GRID_Y(GRID_Y),
    .GRID_Z(GRID_Z)
  ) u_front (
    .push     (push),
    .mode     (mode),
    .pos_x    (pos_x),
    .pos_y    (pos_y),
    .pos_z    (pos_z),
    .block_id (block_id),
    .cmd_full (cmd_full),
    .cmd_push (cmd_push),
    .cmd      (cmd_in)
  );

  vvfm_fifo #(
    .WIDTH($bits(cmd_t)),
    .DEPTH(CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .din   (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .dout  (cmd_head),
    .empty (cmd_empty)
  );

  vvfm_back #(
    .GRID_X(GRID_X),
    .GRID_Y(GRID_Y),
    .GRID_Z(GRID_Z)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .cmd_head  (cmd_head),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .out_full  (out_full),
    .out_push  (out_push),
    .res       (res)
  );

  vvfm_fifo #(
    .WIDTH($bits(result_t)),
    .DEPTH(OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .din   (res),
    .full  (out_full),
    .pop   (pop),
    .dout  (res_out),
    .empty (empty)
  );

  assign face        = res_out.face;
  assign base_vertex = res_out.base_vertex;
  assign world_x     = res_out.world_x;
  assign world_y     = res_out.world_y;
  assign world_z     = res_out.world_z;
  assign last        = res_out.last;

endmodule

/* hw/rtl/vvfm_fifo.sv */
// ----------------------------------------------------------------------------
// vvfm_fifo
// Small register FIFO used between the mesher stages and on the result side.
// ----------------------------------------------------------------------------
module vvfm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [PW:0]      count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == (PW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr + 1'b1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr + 1'b1);
      end
      if (do_push && !do_pop) begin
        count <= (PW+1)'(count + 1'b1);
      end else if (do_pop && !do_push) begin
        count <= (PW+1)'(count - 1'b1);
      end
    end
  end

endmodule

/* hw/rtl/vvfm_front.sv */
// ----------------------------------------------------------------------------
// vvfm_front
// Input side: decodes the mode, drops unused modes and off-grid positions,
// flags grid edges and queues a command word.
// ----------------------------------------------------------------------------
module vvfm_front
  import vvfm_pkg::*;
#(
  parameter int GRID_X = 16,
  parameter int GRID_Y = 16,
  parameter int GRID_Z = 128
) (
  input  logic       push,
  input  logic [1:0] mode,
  input  logic [3:0] pos_x,
  input  logic [3:0] pos_y,
  input  logic [6:0] pos_z,
  input  logic [7:0] block_id,
  input  logic       cmd_full,
  output logic       cmd_push,
  output cmd_t       cmd
);

  logic in_grid;
  logic keep;

  assign in_grid = (32'(pos_x) < GRID_X) && (32'(pos_y) < GRID_Y) && (32'(pos_z) < GRID_Z);

  always_comb begin
    cmd.pos_x = pos_x;
    cmd.pos_y = pos_y;
    cmd.pos_z = pos_z;
    cmd.solid = (block_id != 8'd0);
    cmd.at_edge[FACE_TOP]    = (32'(pos_z) == GRID_Z - 1);
    cmd.at_edge[FACE_BOTTOM] = (pos_z == 7'd0);
    cmd.at_edge[FACE_FRONT]  = (32'(pos_x) == GRID_X - 1);
    cmd.at_edge[FACE_BACK]   = (pos_x == 4'd0);
    cmd.at_edge[FACE_RIGHT]  = (32'(pos_y) == GRID_Y - 1);
    cmd.at_edge[FACE_LEFT]   = (pos_y == 4'd0);
    cmd.op = OP_RESTART;
    keep   = 1'b0;
    unique case (mode)
      MODE_WRITE: begin
        cmd.op = OP_WRITE;
        keep   = in_grid;
      end
      MODE_EMIT: begin
        cmd.op = OP_EMIT;
        keep   = in_grid;
      end
      MODE_RESTART: begin
        cmd.op = OP_RESTART;
        keep   = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign cmd_push = push && !cmd_full && keep;

endmodule

/* hw/rtl/vvfm_back.sv */
// ----------------------------------------------------------------------------
// vvfm_back
// Execution side: occupancy memory, neighbor scan, vertex counter and face
// result generation.
// ----------------------------------------------------------------------------
module vvfm_back
  import vvfm_pkg::*;
#(
  parameter int GRID_X = 16,
  parameter int GRID_Y = 16,
  parameter int GRID_Z = 128
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [9:0] cfg_data,
  input  cmd_t       cmd_head,
  input  logic       cmd_empty,
  output logic       cmd_pop,
  input  logic       out_full,
  output logic       out_push,
  output result_t    res
);

  localparam int CELLS  = GRID_X * GRID_Y * GRID_Z;
  localparam int CELL_W = $clog2(CELLS);
  localparam logic [CELL_W-1:0] OFF_X = CELL_W'(1);
  localparam logic [CELL_W-1:0] OFF_Y = CELL_W'(GRID_X);
  localparam logic [CELL_W-1:0] OFF_Z = CELL_W'(GRID_X * GRID_Y);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_TAIL = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t                 state;
  state_t                 state_next;
  logic                   occ [CELLS];
  logic                   mem_rd;
  logic                   mem_we;
  logic [CELL_W-1:0]      raddr;
  logic [CELL_W-1:0]      head_idx;
  logic [CELL_W-1:0]      self_idx;
  logic [NUM_FACES-1:0]   at_edge;
  logic [NUM_FACES-1:0]   vis;
  logic [NUM_FACES-1:0]   vis_rest;
  logic                   self_solid;
  logic [2:0]             st;
  logic                   rd_pend;
  logic [2:0]             rd_step;
  logic [2:0]             rd_face;
  logic [19:0]            vcount;
  logic [9:0]             block_size;
  logic [13:0]            wx;
  logic [13:0]            wy;
  logic [16:0]            wz;
  logic [2:0]             cur_face;

  assign head_idx = CELL_W'((CELL_W'(cmd_head.pos_z) * CELL_W'(GRID_Y) + CELL_W'(cmd_head.pos_y))
                    * CELL_W'(GRID_X) + CELL_W'(cmd_head.pos_x));

  assign cmd_pop = (state == S_IDLE) && !cmd_empty;
  assign mem_we  = cmd_pop && (cmd_head.op == OP_WRITE);

  always_comb begin
    raddr = self_idx;
    if (st != 3'd0 && !at_edge[3'(st - 3'd1)]) begin
      unique case (3'(st - 3'd1))
        FACE_TOP:    raddr = self_idx + OFF_Z;
        FACE_BOTTOM: raddr = self_idx - OFF_Z;
        FACE_FRONT:  raddr = self_idx + OFF_X;
        FACE_BACK:   raddr = self_idx - OFF_X;
        FACE_RIGHT:  raddr = self_idx + OFF_Y;
        FACE_LEFT:   raddr = self_idx - OFF_Y;
        default:     raddr = self_idx;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      occ[head_idx] <= cmd_head.solid;
    end
    mem_rd <= occ[raddr];
  end

  assign cur_face = lowest_face(vis);
  assign vis_rest = vis & ~NUM_FACES'(6'd1 << cur_face);
  assign out_push = (state == S_EMIT) && (vis != '0) && !out_full;
  assign rd_face  = 3'(rd_step - 3'd1);

  always_comb begin
    res.face        = cur_face;
    res.base_vertex = vcount;
    res.world_x     = wx;
    res.world_y     = wy;
    res.world_z     = wz;
    res.last        = (vis_rest == '0);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (cmd_pop && cmd_head.op == OP_EMIT) state_next = S_SCAN;
      S_SCAN: if (st == SCAN_LAST) state_next = S_TAIL;
      S_TAIL: state_next = self_solid ? S_EMIT : S_IDLE;
      S_EMIT: if (vis == '0 || (out_push && res.last)) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      vcount     <= '0;
      block_size <= BLOCK_SIZE_RESET;
      rd_pend    <= 1'b0;
      st         <= '0;
    end else begin
      state   <= state_next;
      rd_pend <= (state == S_SCAN);
      if (cfg_we) begin
        block_size <= cfg_data;
      end
      if (cmd_pop && cmd_head.op == OP_RESTART) begin
        vcount <= '0;
      end else if (out_push) begin
        vcount <= vcount + VERTEX_STEP;
      end
      if (state == S_SCAN && st != SCAN_LAST) begin
        st <= 3'(st + 3'd1);
      end else begin
        st <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_step <= st;
    if (cmd_pop && cmd_head.op == OP_EMIT) begin
      self_idx <= head_idx;
      at_edge  <= cmd_head.at_edge;
      vis      <= '0;
      wx       <= 14'(cmd_head.pos_x) * 14'(block_size);
      wy       <= 14'(cmd_head.pos_y) * 14'(block_size);
      wz       <= 17'(cmd_head.pos_z) * 17'(block_size);
    end else if (rd_pend) begin
      if (rd_step == 3'd0) begin
        self_solid <= mem_rd;
      end else begin
        vis[rd_face] <= at_edge[rd_face] ? (rd_face != FACE_BOTTOM) : !mem_rd;
      end
    end else if (out_push) begin
      vis <= vis_rest;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    out_push |-> !out_full)
    else $error("result pushed into full queue");

  a_vcount_step: assert property (@(posedge clk) disable iff (rst)
    out_push |=> vcount == 20'($past(vcount) + VERTEX_STEP))
    else $error("vertex counter did not step by one face");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> state == S_IDLE)
    else $error("command taken while busy");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    out_push && res.last |=> state == S_IDLE)
    else $error("faces continued after last");

  a_solid_only: assert property (@(posedge clk) disable iff (rst)
    out_push |-> self_solid)
    else $error("face emitted for empty voxel");

endmodule

/* verif/voxel_face_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// voxel_face_checker
// Watches the config, push and pop channels of the face mesher, keeps its own
// occupancy grid, vertex counter and block size, works out the face words
// each accepted input word should give, and compares every popped word with
// the oldest one still expected.
// ----------------------------------------------------------------------------
module voxel_face_checker
  import vvfm_pkg::*;
#(
  parameter int GRID_X = 16,
  parameter int GRID_Y = 16,
  parameter int GRID_Z = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [9:0]  cfg_data,
  input  logic        push,
  input  logic        full,
  input  logic [1:0]  mode,
  input  logic [3:0]  pos_x,
  input  logic [3:0]  pos_y,
  input  logic [6:0]  pos_z,
  input  logic [7:0]  block_id,
  input  logic        empty,
  input  logic        pop,
  input  logic [2:0]  face,
  input  logic [19:0] base_vertex,
  input  logic [13:0] world_x,
  input  logic [13:0] world_y,
  input  logic [16:0] world_z,
  input  logic        last,
  output int          errors,
  output int          pending,
  output int          faces_checked
);

  bit          solid_map [0:GRID_X*GRID_Y*GRID_Z-1];
  logic [19:0] vertex_next;
  logic [9:0]  edge_len;
  result_t     expected_faces[$];

  initial begin
    foreach (solid_map[i]) solid_map[i] = 1'b0;
  end

  function automatic bit is_solid(int x, int y, int z);
    if (x < 0 || y < 0 || z < 0 || x >= GRID_X || y >= GRID_Y || z >= GRID_Z)
      return 1'b0;
    return solid_map[(z * GRID_Y + y) * GRID_X + x];
  endfunction

  task automatic flag(string msg);
    errors++;
    $display("ERROR @%0t: %s", $time, msg);
  endtask

  task automatic predict_faces(logic [1:0] m, int x, int y, int z, logic [7:0] id);
    bit [NUM_FACES-1:0] vis;
    int      nvis;
    int      done;
    result_t r;
    case (m)
      MODE_RESTART: vertex_next = '0;
      MODE_WRITE: solid_map[(z * GRID_Y + y) * GRID_X + x] = (id != 8'd0);
      MODE_EMIT: begin
        if (is_solid(x, y, z)) begin
          vis[FACE_TOP]    = (z == GRID_Z - 1) || !is_solid(x, y, z + 1);
          vis[FACE_BOTTOM] = (z != 0) && !is_solid(x, y, z - 1);
          vis[FACE_FRONT]  = (x == GRID_X - 1) || !is_solid(x + 1, y, z);
          vis[FACE_BACK]   = (x == 0) || !is_solid(x - 1, y, z);
          vis[FACE_RIGHT]  = (y == GRID_Y - 1) || !is_solid(x, y + 1, z);
          vis[FACE_LEFT]   = (y == 0) || !is_solid(x, y - 1, z);
          nvis = $countones(vis);
          done = 0;
          for (int f = 0; f < NUM_FACES; f++) begin
            if (vis[f]) begin
              done++;
              r.face        = 3'(f);
              r.base_vertex = vertex_next;
              r.world_x     = 14'(x * int'(edge_len));
              r.world_y     = 14'(y * int'(edge_len));
              r.world_z     = 17'(z * int'(edge_len));
              r.last        = (done == nvis);
              expected_faces.push_back(r);
              vertex_next = vertex_next + VERTEX_STEP;
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      vertex_next = '0;
      edge_len = BLOCK_SIZE_RESET;
      expected_faces.delete();
    end else begin
      if (pop && !empty) begin
        got = {face, base_vertex, world_x, world_y, world_z, last};
        if (expected_faces.size() == 0) begin
          flag($sformatf("unexpected face word %0d vtx %0d", face, base_vertex));
        end else begin
          want = expected_faces.pop_front();
          faces_checked++;
          if (got !== want)
            flag($sformatf({"face word: got f%0d v%0d xyz %0d/%0d/%0d l%0d,",
                            " want f%0d v%0d xyz %0d/%0d/%0d l%0d"},
                           got.face, got.base_vertex, got.world_x, got.world_y,
                           got.world_z, got.last, want.face, want.base_vertex,
                           want.world_x, want.world_y, want.world_z, want.last));
        end
      end
      if (cfg_valid && cfg_ready) edge_len = cfg_data;
      if (push && !full) predict_faces(mode, pos_x, pos_y, pos_z, block_id);
    end
    pending = expected_faces.size();
  end

endmodule

/* verif/tb_voxel_visible_face_mesher_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_voxel_visible_face_mesher_top
// Drives the voxel face mesher: a directed pass over grid corners, hidden and
// empty voxels, counter restart and unused mode, then random phases at
// several block sizes. Emits only touch voxels that were written first.
// Both sides idle in random bursts but in the calm last phase; the checker judges every face word.
// ----------------------------------------------------------------------------
module tb_voxel_visible_face_mesher_top;
  import vvfm_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int GX = 16;
  localparam int GY = 16;
  localparam int GZ = 128;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [9:0]  cfg_data;
  logic        push;
  logic        full;
  logic [1:0]  mode;
  logic [3:0]  pos_x;
  logic [3:0]  pos_y;
  logic [6:0]  pos_z;
  logic [7:0]  block_id;
  logic        empty;
  logic        pop;
  logic [2:0]  face;
  logic [19:0] base_vertex;
  logic [13:0] world_x;
  logic [13:0] world_y;
  logic [16:0] world_z;
  logic        last;

  int errors;
  int pending;
  int faces_checked;
  int words_sent;
  int sizes_used;
  bit calm;
  int cx, cy, cz;
  bit written [0:GX*GY*GZ-1];

  voxel_visible_face_mesher_top dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .push(push), .full(full),
    .mode(mode), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .block_id(block_id),
    .empty(empty), .pop(pop),
    .face(face), .base_vertex(base_vertex), .world_x(world_x), .world_y(world_y),
    .world_z(world_z), .last(last)
  );

  voxel_face_checker face_check (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .push(push), .full(full),
    .mode(mode), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .block_id(block_id),
    .empty(empty), .pop(pop),
    .face(face), .base_vertex(base_vertex), .world_x(world_x), .world_y(world_y),
    .world_z(world_z), .last(last),
    .errors(errors), .pending(pending), .faces_checked(faces_checked)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // result side: random stall bursts, none once calm
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        pop = 1'b0;
        stall--;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        pop = 1'b0;
        stall = $urandom_range(1, 16) - 1;
      end else begin
        pop = 1'b1;
      end
    end
  end

  function automatic int cell_of(int x, int y, int z);
    return (z * GY + y) * GX + x;
  endfunction

  task automatic send_word(logic [1:0] m, int x, int y, int z, logic [7:0] id);
    int gap;
    gap = (!calm && $urandom_range(0, 5) == 0) ? $urandom_range(1, 16) : 0;
    @(negedge clk);
    if (gap > 0) begin
      push = 1'b0;
      repeat (gap) @(negedge clk);
    end
    push = 1'b1;
    mode = m;
    pos_x = 4'(x);
    pos_y = 4'(y);
    pos_z = 7'(z);
    block_id = id;
    do @(posedge clk); while (full);
    if (m == MODE_WRITE) written[cell_of(x, y, z)] = 1'b1;
    if (m != MODE_UNUSED) words_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    push = 1'b0;
    wait (pending == 0);
    repeat (64) @(negedge clk);
  endtask

  task automatic set_block_size(logic [9:0] v);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    sizes_used++;
  endtask

  function automatic logic [7:0] random_id();
    return ($urandom_range(0, 99) < 65) ? 8'($urandom_range(1, 255)) : 8'd0;
  endfunction

  function automatic int near(int base, int span);
    return ($urandom_range(0, 3) == 0) ? $urandom_range(0, span - 1)
                                       : base + $urandom_range(0, 2);
  endfunction

  // write the voxel and its in-grid neighbors where unwritten, some anew
  task automatic prepare_cells(int x, int y, int z);
    int nx, ny, nz;
    for (int k = 0; k < 7; k++) begin
      nx = x;
      ny = y;
      nz = z;
      case (k)
        1: nz = z + 1;
        2: nz = z - 1;
        3: nx = x + 1;
        4: nx = x - 1;
        5: ny = y + 1;
        6: ny = y - 1;
        default: ;
      endcase
      if (nx >= 0 && ny >= 0 && nz >= 0 && nx < GX && ny < GY && nz < GZ) begin
        if (!written[cell_of(nx, ny, nz)] || $urandom_range(0, 5) == 0)
          send_word(MODE_WRITE, nx, ny, nz, random_id());
      end
    end
  endtask

  task automatic run_phase(int words);
    int x, y, z, r, goal;
    goal = words_sent + words;
    while (words_sent < goal) begin
      x = near(cx, GX);
      y = near(cy, GY);
      z = near(cz, GZ);
      r = $urandom_range(0, 99);
      if (r < 70) begin
        prepare_cells(x, y, z);
        send_word(MODE_EMIT, x, y, z, 8'($urandom));
      end else if (r < 82) begin
        send_word(MODE_WRITE, x, y, z, random_id());
      end else if (r < 88) begin
        send_word(MODE_RESTART, x, y, z, 8'($urandom));
      end else if (r < 94) begin
        send_word(MODE_UNUSED, $urandom_range(0, 15), $urandom_range(0, 15),
                  $urandom_range(0, 127), 8'($urandom));
      end else begin
        prepare_cells(x, y, z);
      end
    end
  endtask

  task automatic pick_cluster();
    int pick;
    pick = $urandom_range(0, 2);
    cx = (pick == 0) ? 0 : (pick == 1) ? 6 : 13;
    pick = $urandom_range(0, 2);
    cy = (pick == 0) ? 0 : (pick == 1) ? 6 : 13;
    pick = $urandom_range(0, 2);
    cz = (pick == 0) ? 0 : (pick == 1) ? 60 : 125;
  endtask

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = '0;
    push = 1'b0;
    pop = 1'b0;
    mode = MODE_WRITE;
    pos_x = '0;
    pos_y = '0;
    pos_z = '0;
    block_id = '0;
    calm = 1'b0;
    words_sent = 0;
    sizes_used = 0;
    foreach (written[i]) written[i] = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // origin corner, bottom face suppressed at layer 0
    send_word(MODE_WRITE, 0, 0, 0, 8'd255);
    send_word(MODE_WRITE, 1, 0, 0, 8'd0);
    send_word(MODE_WRITE, 0, 1, 0, 8'd1);
    send_word(MODE_WRITE, 0, 0, 1, 8'd128);
    send_word(MODE_EMIT, 0, 0, 0, 8'd0);
    // far corner, all six faces
    send_word(MODE_WRITE, 15, 15, 127, 8'd127);
    send_word(MODE_WRITE, 14, 15, 127, 8'd0);
    send_word(MODE_WRITE, 15, 14, 127, 8'd0);
    send_word(MODE_WRITE, 15, 15, 126, 8'd0);
    send_word(MODE_EMIT, 15, 15, 127, 8'hFF);
    // fully enclosed voxel, then the same voxel emptied
    send_word(MODE_WRITE, 5, 5, 5, 8'd2);
    send_word(MODE_WRITE, 5, 5, 6, 8'd4);
    send_word(MODE_WRITE, 5, 5, 4, 8'd8);
    send_word(MODE_WRITE, 6, 5, 5, 8'd16);
    send_word(MODE_WRITE, 4, 5, 5, 8'd32);
    send_word(MODE_WRITE, 5, 6, 5, 8'd64);
    send_word(MODE_WRITE, 5, 4, 5, 8'd128);
    send_word(MODE_EMIT, 5, 5, 5, 8'd0);
    send_word(MODE_WRITE, 5, 5, 5, 8'd0);
    send_word(MODE_EMIT, 5, 5, 5, 8'd0);
    // restart counter, unused mode, far corner again from vertex zero
    send_word(MODE_RESTART, 15, 15, 127, 8'hFF);
    send_word(MODE_UNUSED, 15, 15, 127, 8'hFF);
    send_word(MODE_EMIT, 15, 15, 127, 8'd0);
    send_word(MODE_EMIT, 0, 0, 0, 8'd0);
    drain();

    set_block_size(10'd1023);
    pick_cluster();
    run_phase(120);
    drain();

    set_block_size(10'd1);
    pick_cluster();
    run_phase(120);
    drain();

    set_block_size(10'($urandom_range(2, 1022)));
    pick_cluster();
    run_phase(130);
    drain();

    set_block_size(10'($urandom_range(1, 1023)));
    pick_cluster();
    calm = 1'b1;
    run_phase(130);
    drain();

    $display("Sent %0d input words over %0d block size settings.", words_sent, sizes_used);
    $display("Checked %0d face words against the prediction.", faces_checked);
    if (errors == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
